FILE: sv/fdts_pkg.sv
package fdts_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned QueueDepthDef = 128;
  localparam int unsigned ServersDef    = 3;

  // Fixed field widths of the request and result channels
  localparam int unsigned JobW    = 16;
  localparam int unsigned TicksW  = 8;
  localparam int unsigned EventW  = 3;
  localparam int unsigned SrvOutW = 2;
  localparam int unsigned QueuedW = 7;

  // Result event codes
  typedef enum logic [EventW-1:0] {
    EvAccepted = 3'd0,
    EvDropped  = 3'd1,
    EvStarted  = 3'd2,
    EvFinished = 3'd3,
    EvDone     = 3'd4
  } event_e;

  // Request action codes
  typedef enum logic {
    ActEnqueue = 1'b0,
    ActTick    = 1'b1
  } action_e;

  // Executor sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StVisit,
    StStart,
    StDone
  } state_e;

  // Classified command passed from the front end to the executor
  typedef struct packed {
    logic              tick;
    logic [JobW-1:0]   job_id;
    logic [TicksW-1:0] ticks;
  } cmd_t;

  // One queue slot: service time on top, job id below
  typedef struct packed {
    logic [TicksW-1:0] ticks;
    logic [JobW-1:0]   job_id;
  } job_t;

endpackage

FILE: sv/fdts_front.sv
module fdts_front import fdts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [JobW-1:0]   job_id_i,
  input  logic [TicksW-1:0] service_ticks_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  // Two-entry command queue between intake and executor
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  cmd_t       cmd_new;

  // Classify request; a zero service time counts as one tick
  always_comb begin
    cmd_new.tick   = (action_e'(action_i) == ActTick);
    cmd_new.job_id = job_id_i;
    cmd_new.ticks  = (service_ticks_i == '0) ? TicksW'(1) : service_ticks_i;
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !cmd_pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: sv/fdts_back.sv
module fdts_back import fdts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned SERVERS     = ServersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EventW-1:0]  event_res_o,
  output logic [SrvOutW-1:0] server_o,
  output logic [JobW-1:0]    job_o,
  output logic [QueuedW-1:0] queued_o,
  output logic               all_idle_o,
  output logic               last_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SrvW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [SrvW-1:0] SrvLast = SrvW'(SERVERS - 1);
  localparam logic [PtrW:0]   DepthExt = (PtrW+1)'(QUEUE_DEPTH);

  // Job ring storage and registered head read
  job_t mem [QUEUE_DEPTH];
  job_t rd_q;
  logic mem_we;

  state_e state_q, state_d;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0]   head_nxt, tail_nxt;
  logic [SERVERS-1:0] busy_q, busy_d;
  logic [JobW-1:0]   sjob_q [SERVERS];
  logic [JobW-1:0]   sjob_d [SERVERS];
  logic [TicksW-1:0] left_q [SERVERS];
  logic [TicksW-1:0] left_d [SERVERS];
  logic [SrvW-1:0]   idx_q, idx_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  event_e             ev_q, ev_d;
  logic [SrvOutW-1:0] srv_q, srv_d;
  logic [JobW-1:0]    job_q, job_d;
  logic [QueuedW-1:0] queued_q, queued_d;
  logic               idle_q, idle_d;
  logic               last_q, last_d;

  logic            out_free, full, q_empty, srv_last, srv_busy, srv_finish;
  logic            emit;
  logic [PtrW:0]   cnt_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign head_nxt   = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
  assign tail_nxt   = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
  assign full       = (tail_nxt == head_q);
  assign q_empty    = (head_q == tail_q);
  assign srv_last   = (idx_q == SrvLast);
  assign srv_busy   = busy_q[idx_q];
  assign srv_finish = (left_q[idx_q] == TicksW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && cmd_i.tick) state_d = StVisit;
      end
      StVisit: begin
        if (srv_busy) begin
          if (!srv_finish || out_free) state_d = srv_last ? StDone : StVisit;
        end else if (!q_empty) begin
          state_d = StStart;
        end else begin
          state_d = srv_last ? StDone : StVisit;
        end
      end
      StStart: begin
        if (out_free) state_d = srv_last ? StDone : StVisit;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and result generation
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    busy_d    = busy_q;
    sjob_d    = sjob_q;
    left_d    = left_q;
    idx_d     = idx_q;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    ev_d      = EvDone;
    srv_d     = '0;
    job_d     = '0;
    last_d    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && !cmd_i.tick && out_free) begin
          cmd_pop_o = 1'b1;
          emit      = 1'b1;
          job_d     = cmd_i.job_id;
          last_d    = 1'b1;
          if (full) begin
            ev_d = EvDropped;
          end else begin
            ev_d   = EvAccepted;
            mem_we = 1'b1;
            tail_d = tail_nxt;
          end
        end
      end
      StVisit: begin
        if (srv_busy) begin
          if (srv_finish) begin
            if (out_free) begin
              busy_d[idx_q] = 1'b0;
              left_d[idx_q] = '0;
              emit          = 1'b1;
              ev_d          = EvFinished;
              srv_d         = SrvOutW'(idx_q);
              job_d         = sjob_q[idx_q];
              if (!srv_last) idx_d = idx_q + SrvW'(1);
            end
          end else begin
            left_d[idx_q] = left_q[idx_q] - TicksW'(1);
            if (!srv_last) idx_d = idx_q + SrvW'(1);
          end
        end else if (q_empty) begin
          if (!srv_last) idx_d = idx_q + SrvW'(1);
        end
      end
      StStart: begin
        if (out_free) begin
          head_d        = head_nxt;
          busy_d[idx_q] = 1'b1;
          sjob_d[idx_q] = rd_q.job_id;
          left_d[idx_q] = rd_q.ticks;
          emit          = 1'b1;
          ev_d          = EvStarted;
          srv_d         = SrvOutW'(idx_q);
          job_d         = rd_q.job_id;
          if (!srv_last) idx_d = idx_q + SrvW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          emit      = 1'b1;
          ev_d      = EvDone;
          last_d    = 1'b1;
          cmd_pop_o = 1'b1;
          idx_d     = '0;
        end
      end
      default: ;
    endcase
  end

  // Queue level and idle flag as seen after this event
  always_comb begin
    cnt_d = (PtrW+1)'(tail_d) - (PtrW+1)'(head_d);
    if (tail_d < head_d) cnt_d = cnt_d + DepthExt;
    queued_d = QueuedW'(cnt_d);
    idle_d   = (head_d == tail_d) && (busy_d == '0);
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      busy_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        sjob_q[i] <= '0;
        left_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      sjob_q      <= sjob_d;
      left_q      <= left_d;
    end
  end

  // Result payload, loaded when a result is produced
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_q     <= ev_d;
      srv_q    <= srv_d;
      job_q    <= job_d;
      queued_q <= queued_d;
      idle_q   <= idle_d;
      last_q   <= last_d;
    end
  end

  // Ring memory: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= job_t'{ticks: cmd_i.ticks, job_id: cmd_i.job_id};
    end
    rd_q <= mem[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign server_o    = srv_q;
  assign job_o       = job_q;
  assign queued_o    = queued_q;
  assign all_idle_o  = idle_q;
  assign last_o      = last_q;

endmodule

FILE: sv/fifo_dispatch_to_timed_servers.sv
// Channel   Handshake                 Payload
// request   in_valid_i / in_ready_o    action_i, job_id_i, service_ticks_i
// result    out_valid_o / out_ready_i  event_res_o, server_o, job_o, queued_o,
//                                      all_idle_o, last_o
//
// A request is registered in the command queue before the executor sees it.
// An enqueue is then handled in the executor's idle state. A tick passes
// through the idle state to dispatch, a visit to each server, a start state
// for each job started, which uses the registered read of the ring memory,
// and the done result. Reset clears pointers, server state and the command
// queue; ring contents are left as they are. A two-entry command queue keeps
// intake running while the executor waits on a stalled result register.
module fifo_dispatch_to_timed_servers import fdts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned SERVERS     = ServersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [JobW-1:0]    job_id_i,
  input  logic [TicksW-1:0]  service_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EventW-1:0]  event_res_o,
  output logic [SrvOutW-1:0] server_o,
  output logic [JobW-1:0]    job_o,
  output logic [QueuedW-1:0] queued_o,
  output logic               all_idle_o,
  output logic               last_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Intake and classification
  fdts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .job_id_i        (job_id_i),
    .service_ticks_i (service_ticks_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Queue ring, servers and result register
  fdts_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SERVERS     (SERVERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .server_o    (server_o),
    .job_o       (job_o),
    .queued_o    (queued_o),
    .all_idle_o  (all_idle_o),
    .last_o      (last_o)
  );

endmodule

FILE: dv/fdts_checker.sv
module fdts_checker import fdts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned SERVERS     = ServersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               action_i,
  input  logic [JobW-1:0]    job_id_i,
  input  logic [TicksW-1:0]  service_ticks_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [EventW-1:0]  event_res_i,
  input  logic [SrvOutW-1:0] server_i,
  input  logic [JobW-1:0]    job_i,
  input  logic [QueuedW-1:0] queued_i,
  input  logic               all_idle_i,
  input  logic               last_i,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o
);

  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    event_e             ev;
    logic [SrvOutW-1:0] srv;
    logic [JobW-1:0]    job;
    logic [QueuedW-1:0] queued;
    logic               idle;
    logic               last;
  } dispatch_event_t;

  // Shadow of the dispatcher: job ring plus per-server state
  job_t            ring [QUEUE_DEPTH];
  int unsigned     head;
  int unsigned     tail;
  logic            srv_busy [SERVERS];
  logic [JobW-1:0] srv_job [SERVERS];
  logic [TicksW-1:0] srv_left [SERVERS];

  dispatch_event_t pending_events [$];
  int unsigned     mismatches = 0;

  function automatic int unsigned jobs_waiting();
    return (tail + QUEUE_DEPTH - head) % QUEUE_DEPTH;
  endfunction

  function automatic logic system_idle();
    if (head != tail) return 1'b0;
    for (int s = 0; s < SERVERS; s++)
      if (srv_busy[s]) return 1'b0;
    return 1'b1;
  endfunction

  // Queue one expected event; queued and idle reflect state after the event
  function automatic void post_event(input event_e ev, input int unsigned srv,
                                     input logic [JobW-1:0] id, input logic lst);
    dispatch_event_t r;
    r.ev     = ev;
    r.srv    = SrvOutW'(srv);
    r.job    = id;
    r.queued = QueuedW'(jobs_waiting());
    r.idle   = system_idle();
    r.last   = lst;
    pending_events.push_back(r);
  endfunction

  // Apply one accepted request to the shadow state and list its events
  function automatic void dispatch_step(input action_e act, input logic [JobW-1:0] id,
                                        input logic [TicksW-1:0] tk);
    job_t slot;
    if (act == ActEnqueue) begin
      if ((tail + 1) % QUEUE_DEPTH == head) begin
        post_event(EvDropped, 0, id, 1'b1);
      end else begin
        slot.job_id = id;
        // zero service time counts as one tick
        slot.ticks  = (tk == '0) ? TicksW'(1) : tk;
        ring[tail]  = slot;
        tail        = (tail + 1) % QUEUE_DEPTH;
        post_event(EvAccepted, 0, id, 1'b1);
      end
    end else begin
      for (int s = 0; s < SERVERS; s++) begin
        if (srv_busy[s]) begin
          srv_left[s] = srv_left[s] - 1'b1;
          if (srv_left[s] == '0) begin
            srv_busy[s] = 1'b0;
            post_event(EvFinished, s, srv_job[s], 1'b0);
          end
        end else if (head != tail) begin
          slot        = ring[head];
          head        = (head + 1) % QUEUE_DEPTH;
          srv_busy[s] = 1'b1;
          srv_job[s]  = slot.job_id;
          srv_left[s] = slot.ticks;
          post_event(EvStarted, s, slot.job_id, 1'b0);
        end
      end
      post_event(EvDone, 0, '0, 1'b1);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Compare results first, then predict the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_event_t want;
    if (!rst_ni) begin
      head = 0;
      tail = 0;
      for (int s = 0; s < SERVERS; s++) begin
        srv_busy[s] = 1'b0;
        srv_job[s]  = '0;
        srv_left[s] = '0;
      end
      pending_events.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (event %0d job %0d)",
                                    event_res_i, job_i));
        end else begin
          want = pending_events.pop_front();
          if (event_res_i !== want.ev)
            report_mismatch($sformatf("event_res got %0d want %0d", event_res_i, want.ev));
          if (server_i !== want.srv)
            report_mismatch($sformatf("server got %0d want %0d", server_i, want.srv));
          if (job_i !== want.job)
            report_mismatch($sformatf("job got %0h want %0h", job_i, want.job));
          if (queued_i !== want.queued)
            report_mismatch($sformatf("queued got %0d want %0d", queued_i, want.queued));
          if (all_idle_i !== want.idle)
            report_mismatch($sformatf("all_idle got %0b want %0b", all_idle_i, want.idle));
          if (last_i !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", last_i, want.last));
        end
      end
      if (in_valid_i && in_ready_i)
        dispatch_step(action_e'(action_i), job_id_i, service_ticks_i);
    end
    fail_cnt_o <= mismatches;
    pending_o  <= pending_events.size();
  end

endmodule

FILE: dv/fifo_dispatch_to_timed_servers_tb.sv
module fifo_dispatch_to_timed_servers_tb import fdts_pkg::*;;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned RxHoldCycles = 400;
  localparam int unsigned DrainCycles  = 32;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic [JobW-1:0]    job_id_i;
  logic [TicksW-1:0]  service_ticks_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [EventW-1:0]  event_res_o;
  logic [SrvOutW-1:0] server_o;
  logic [JobW-1:0]    job_o;
  logic [QueuedW-1:0] queued_o;
  logic               all_idle_o;
  logic               last_o;

  int unsigned mismatch_cnt;
  int unsigned events_due;
  int unsigned cycle_cnt = 0;
  bit          steady    = 1'b0;
  bit          rx_hold   = 1'b0;

  fifo_dispatch_to_timed_servers u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .job_id_i        (job_id_i),
    .service_ticks_i (service_ticks_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_o     (event_res_o),
    .server_o        (server_o),
    .job_o           (job_o),
    .queued_o        (queued_o),
    .all_idle_o      (all_idle_o),
    .last_o          (last_o)
  );

  fdts_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .action_i        (action_i),
    .job_id_i        (job_id_i),
    .service_ticks_i (service_ticks_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_i     (event_res_o),
    .server_i        (server_o),
    .job_i           (job_o),
    .queued_i        (queued_o),
    .all_idle_i      (all_idle_o),
    .last_i          (last_o),
    .fail_cnt_o      (mismatch_cnt),
    .pending_o       (events_due)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL fifo_dispatch_to_timed_servers");
      $finish;
    end
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Short service times keep servers cycling; occasionally the full range
  function automatic logic [TicksW-1:0] pick_ticks();
    if ($urandom_range(0, 99) < 8) return TicksW'($urandom_range(0, 255));
    return TicksW'($urandom_range(1, 4));
  endfunction

  task automatic send_request(input action_e act, input logic [JobW-1:0] id,
                              input logic [TicksW-1:0] tk);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    job_id_i        <= id;
    service_ticks_i <= tk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic wait_settled();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (events_due != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned tick_pct);
    if ($urandom_range(0, 99) < tick_pct)
      send_request(ActTick, JobW'($urandom), TicksW'($urandom));
    else
      send_request(ActEnqueue, JobW'($urandom_range(0, 65535)), pick_ticks());
  endtask

  // Result side: random ready runs, plus one long hold-off on request
  initial begin
    int unsigned stall;
    bit          held;
    held        = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold && !held) begin
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        held = 1'b1;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        stall = idle_len();
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // Request side
  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ActEnqueue;
    job_id_i        <= '0;
    service_ticks_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tick, id and service extremes, zero service time
    send_request(ActTick, '0, '0);
    send_request(ActEnqueue, 16'h0000, 8'd1);
    send_request(ActEnqueue, 16'hFFFF, 8'd255);
    send_request(ActEnqueue, 16'h5A5A, 8'd0);
    send_request(ActEnqueue, 16'hA5A5, 8'd2);
    send_request(ActEnqueue, 16'h8001, 8'd3);
    repeat (3) send_request(ActTick, 16'hFFFF, 8'hFF);
    send_request(ActEnqueue, 16'h0001, 8'd3);
    send_request(ActEnqueue, 16'h0002, 8'd1);
    send_request(ActEnqueue, 16'h7FFE, 8'd128);
    repeat (6) send_request(ActTick, '0, '0);
    wait_settled();

    // Random mix
    for (int k = 0; k < 30; k++) send_random(50);

    // Fill the ring past full while results are held back
    wait_settled();
    rx_hold = 1'b1;
    for (int k = 0; k < 130; k++)
      send_request(ActEnqueue, JobW'($urandom_range(0, 65535)),
                   TicksW'($urandom_range(1, 3)));
    wait_settled();

    // Tick-heavy drain, first without gaps, then with
    steady = 1'b1;
    for (int k = 0; k < 25; k++) send_random(75);
    steady = 1'b0;
    for (int k = 0; k < 25; k++) send_random(75);

    wait_settled();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS fifo_dispatch_to_timed_servers");
    end else begin
      $display("FAIL fifo_dispatch_to_timed_servers");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fdts_pkg.sv
sv/fdts_front.sv
sv/fdts_back.sv
sv/fifo_dispatch_to_timed_servers.sv
dv/fdts_checker.sv
dv/fifo_dispatch_to_timed_servers_tb.sv
